[rtl/ifc_pkg.sv]
// Package for the two-lane int/float conversion unit.
// Holds the conversion kind codes and shared widths; no dependencies.
package ifc_pkg;
  localparam int LanesDef = 2;
  localparam int LaneW = 32;
  localparam int TagW = 5;

  typedef enum logic [1:0] {
    KIND_S2F = 2'd0,
    KIND_U2F = 2'd1,
    KIND_F2S = 2'd2,
    KIND_F2U = 2'd3
  } kind_e;
endpackage

[rtl/ifc_lane.sv]
// One lane: int32/uint32 <-> IEEE single, combinational with output register.
// Depends on ifc_pkg.
module ifc_lane (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  ifc_pkg::kind_e          kind_i,
  input  logic [ifc_pkg::LaneW-1:0] x_i,
  output logic [ifc_pkg::LaneW-1:0] res_o
);
  logic        sign;
  logic [7:0]  expo;
  logic [22:0] frac;
  logic [31:0] mag, norm, tmag, res_d, res_q;
  logic [4:0]  p;
  logic [7:0]  rbits;
  logic        rnd;
  logic [24:0] m;
  logic [31:0] ival;
  logic [55:0] wide;
  logic [4:0]  pe;

  assign sign = x_i[31];
  assign expo = x_i[30:23];
  assign frac = x_i[22:0];

  always_comb begin
    mag = (kind_i == ifc_pkg::KIND_S2F && sign) ? (32'd0 - x_i) : x_i;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) p = 5'(i);
    end
    norm = mag << (5'd31 - p);
    // norm[31] leading one, [30:8] mantissa, [7] guard, [6:0] sticky
    rbits = norm[7:0];
    rnd = rbits[7] && ((|rbits[6:0]) || norm[8]);
    m = {1'b0, norm[31:8]} + {24'd0, rnd};
    ival = {((kind_i == ifc_pkg::KIND_S2F) ? sign : 1'b0), 31'd0}
         + ({24'd0, 8'd127 + {3'd0, p}} << 23)
         + ({7'd0, m} - 32'h0080_0000);
    pe = 5'(expo - 8'd127);
    wide = {32'd0, 1'b1, frac} << pe;
    tmag = wide[54:23];
    res_d = 32'd0;
    case (kind_i)
      ifc_pkg::KIND_S2F, ifc_pkg::KIND_U2F: res_d = (mag == 32'd0) ? 32'd0 : ival;
      ifc_pkg::KIND_F2S: begin
        if (expo == 8'hFF && frac != 23'd0) res_d = 32'd0;
        else if (expo >= 8'd158) res_d = sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (expo < 8'd127) res_d = 32'd0;
        else res_d = sign ? (32'd0 - tmag) : tmag;
      end
      ifc_pkg::KIND_F2U: begin
        if (expo == 8'hFF && frac != 23'd0) res_d = 32'd0;
        else if (sign) res_d = 32'd0;
        else if (expo >= 8'd159) res_d = 32'hFFFF_FFFF;
        else if (expo < 8'd127) res_d = 32'd0;
        else res_d = tmag;
      end
      default: res_d = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end
  assign res_o = res_q;
endmodule

[rtl/int_float_convert_two_lane_unit.sv]
// Top level of the two-lane int/float conversion unit.
// Depends on ifc_pkg and ifc_lane.
// Converts both 32-bit lanes of a register together: one transaction per
// clock, with results held in the lane output registers; a result that
// waits at the output holds off the next transaction until it is taken.
// Lanes at or beyond LANES give zero.
module int_float_convert_two_lane_unit #(
  parameter int LANES = ifc_pkg::LanesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                kind_i,
  input  logic [ifc_pkg::TagW-1:0]  dest_reg_i,
  input  logic [ifc_pkg::LaneW-1:0] src_lane0_i,
  input  logic [ifc_pkg::LaneW-1:0] src_lane1_i,
  input  logic                      last_reg_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ifc_pkg::TagW-1:0]  out_reg_o,
  output logic [ifc_pkg::LaneW-1:0] res_lane0_o,
  output logic [ifc_pkg::LaneW-1:0] res_lane1_o,
  output logic                      out_last_o
);
  logic                      valid_q;
  logic                      load;
  logic [ifc_pkg::TagW-1:0]  reg_q;
  logic                      last_q;
  logic [ifc_pkg::LaneW-1:0] src [2];
  logic [ifc_pkg::LaneW-1:0] res [2];

  assign in_ready_o = !valid_q || out_ready_i;
  assign load = in_valid_i && in_ready_o;
  assign src[0] = src_lane0_i;
  assign src[1] = src_lane1_i;

  for (genvar g = 0; g < 2; g++) begin : g_lane
    if (g < LANES) begin : g_on
      ifc_lane u_lane (
        .clk_i (clk_i),
        .en_i  (load),
        .kind_i(ifc_pkg::kind_e'(kind_i)),
        .x_i   (src[g]),
        .res_o (res[g])
      );
    end else begin : g_off
      assign res[g] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      reg_q  <= dest_reg_i;
      last_q <= last_reg_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_reg_o   = reg_q;
  assign out_last_o  = last_q;
  assign res_lane0_o = res[0];
  assign res_lane1_o = res[1];
endmodule
